@@ rtl/core/baro_temp_pressure_compensate_unit_macros.svh @@
// Assertion macros shared by the barometric compensation RTL.
// Depends on the including module having clk and rst_n in scope.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_UNIT_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/btpc_pkg.sv @@
// Package for the barometric compensation unit: widths, codes, constants and stage types.
// No dependencies; used by the interfaces and the top level.
package btpc_pkg;

  localparam int UT_W   = 16;
  localparam int UP_W   = 19;
  localparam int TEMP_W = 16;
  localparam int PRES_W = 20;
  localparam int STAT_W = 2;
  localparam int OSS_W  = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Divider geometry: temperature divide (mc*2048 / den) and pressure divide.
  localparam int DIVA_NUM_W = 27;
  localparam int DIVA_DEN_W = 20;
  localparam int DIVB_NUM_W = 32;
  localparam int DIVB_DEN_W = 17;

  localparam int B6_OFFSET = 4000;
  localparam int B4_OFFSET = 32768;
  localparam int P_SCALE   = 50000;
  localparam int P_SQ_K    = 3038;
  localparam int P_LIN_K   = 7357;
  localparam int P_OFFSET  = 3791;
  localparam int TEMP_MAX  = 32767;
  localparam int TEMP_MIN  = -32768;
  localparam int PRES_MAX  = 1048575;
  localparam logic [OSS_W-1:0] OSS_RESET = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_A1A2 = 3'd0,
    REG_A3A4 = 3'd1,
    REG_A5A6 = 3'd2,
    REG_B1B2 = 3'd3,
    REG_CD   = 3'd4,
    REG_OSS  = 3'd5
  } reg_idx_t;

  // Side data carried through the temperature divider.
  typedef struct packed {
    logic signed [18:0] x1;
    logic [UP_W-1:0]    up;
    logic               dz;
    logic               neg;
  } side_a_t;

  // Temperature result and flags that follow the item to the end.
  typedef struct packed {
    logic signed [TEMP_W-1:0] t;
    logic                     tsat;
    logic                     dz;
  } tag_t;

  // Side data carried through the pressure divider.
  typedef struct packed {
    tag_t tag;
    logic big;
  } side_b_t;

endpackage

@@ rtl/core/btpc_if.sv @@
// Stream interfaces for the compensation unit's input and result channels.
// Depends on btpc_pkg for field widths.
interface btpc_in_if;
  import btpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [UT_W-1:0]  raw_temperature;
  logic [UP_W-1:0]  raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btpc_out_if;
  import btpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic [PRES_W-1:0]        pressure_pa;
  logic [STAT_W-1:0]        status;
  modport source (output valid, temperature_tenths, pressure_pa, status, input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, status, output ready);
endinterface

@@ rtl/core/baro_temp_pressure_compensate_unit.sv @@
// Top level of the barometric temperature and pressure compensation unit.
// Depends on btpc_pkg, btpc_if, btpc_div and the assertion macro header.
//
//   channel   | direction | handshake             | contents
//   in_chan   | in        | valid/ready           | raw_temperature, raw_pressure
//   out_chan  | out       | valid/ready           | temperature_tenths, pressure_pa, status
//   cfg (APB) | in        | psel/penable, pready  | five coefficient words, oversampling
//
// One item enters per cycle while the pipeline is not held; each passes every registered stage to its result.
// The two bit-per-stage dividers (27 and 32 stages) make up most of the pipeline.
// Reset is synchronous, active low; it clears valid bits and loads register defaults.
// When the result register is full and not taken, the whole pipeline holds in place.
`include "baro_temp_pressure_compensate_unit_macros.svh"
module baro_temp_pressure_compensate_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  btpc_in_if.sink                      in_chan,
  btpc_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [btpc_pkg::DATA_W-1:0]  pwdata,
  output logic [btpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import btpc_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] coeff_a1_a2_r, coeff_a3_a4_r, coeff_a5_a6_r, coeff_b1_b2_r, coeff_c_d_r;
  logic [OSS_W-1:0]  oss_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a1_a2_r <= '0;
      coeff_a3_a4_r <= '0;
      coeff_a5_a6_r <= '0;
      coeff_b1_b2_r <= '0;
      coeff_c_d_r   <= '0;
      oss_r         <= OSS_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_A1A2: coeff_a1_a2_r <= pwdata;
        REG_A3A4: coeff_a3_a4_r <= pwdata;
        REG_A5A6: coeff_a5_a6_r <= pwdata;
        REG_B1B2: coeff_b1_b2_r <= pwdata;
        REG_CD:   coeff_c_d_r   <= pwdata;
        REG_OSS:  oss_r         <= pwdata[OSS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_A1A2: prdata = coeff_a1_a2_r;
      REG_A3A4: prdata = coeff_a3_a4_r;
      REG_A5A6: prdata = coeff_a5_a6_r;
      REG_B1B2: prdata = coeff_b1_b2_r;
      REG_CD:   prdata = coeff_c_d_r;
      REG_OSS:  prdata = {{(DATA_W-OSS_W){1'b0}}, oss_r};
      default:  prdata = '0;
    endcase
  end

  // Calibration fields.
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = $signed(coeff_a1_a2_r[31:16]);
  assign ac2 = $signed(coeff_a1_a2_r[15:0]);
  assign ac3 = $signed(coeff_a3_a4_r[31:16]);
  assign ac4 = coeff_a3_a4_r[15:0];
  assign ac5 = coeff_a5_a6_r[31:16];
  assign ac6 = coeff_a5_a6_r[15:0];
  assign b1  = $signed(coeff_b1_b2_r[31:16]);
  assign b2  = $signed(coeff_b1_b2_r[15:0]);
  assign mc  = $signed(coeff_c_d_r[31:16]);
  assign md  = $signed(coeff_c_d_r[15:0]);

  // Pipeline advance: everything moves unless the result register is stuck.
  logic out_vld_r, en;
  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // Valid bits of the plain stages.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic s8_vld_r, s9_vld_r, s10_vld_r, s12_vld_r, s13_vld_r, s14_vld_r;
  logic da_vld, db_vld;

  // Stage 1: (UT - AC6) * AC5.
  logic signed [16:0] ut_d;
  logic signed [33:0] s1_prod_nxt, s1_prod_r;
  logic [UP_W-1:0]    s1_up_r;
  assign ut_d        = $signed({1'b0, in_chan.raw_temperature}) - $signed({1'b0, ac6});
  assign s1_prod_nxt = ut_d * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r <= s1_prod_nxt;
      s1_up_r   <= in_chan.raw_pressure;
    end
  end

  // Stage 2: X1, divisor X1 + MD, and magnitudes for the temperature divide.
  logic signed [18:0]           x1a;
  logic signed [19:0]           den_a;
  logic signed [26:0]           num_a;
  logic [DIVA_NUM_W-1:0]        s2_num_r;
  logic [DIVA_DEN_W-1:0]        s2_den_r;
  side_a_t                      s2_side_nxt, s2_side_r;
  assign x1a   = s1_prod_r[33:15];
  assign den_a = $signed({x1a[18], x1a}) + $signed({{4{md[15]}}, md});
  assign num_a = $signed({mc, 11'b0});
  assign s2_side_nxt = '{x1: x1a, up: s1_up_r, dz: (den_a == '0), neg: mc[15] ^ den_a[19]};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r  <= num_a[26] ? DIVA_NUM_W'(-num_a) : DIVA_NUM_W'(num_a);
      s2_den_r  <= den_a[19] ? DIVA_DEN_W'(-den_a) : DIVA_DEN_W'(den_a);
      s2_side_r <= s2_side_nxt;
    end
  end

  // Temperature divide X2 = MC*2048 / (X1 + MD).
  logic [DIVA_NUM_W-1:0] qa;
  side_a_t               sa;
  btpc_div #(.NUM_W(DIVA_NUM_W), .DEN_W(DIVA_DEN_W), .SIDE_W($bits(side_a_t))) u_div_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s2_vld_r),
    .num(s2_num_r), .den(s2_den_r), .side(s2_side_r),
    .out_vld(da_vld), .quo(qa), .out_side(sa)
  );

  // Stage 3: B5 = X1 + X2 with the quotient sign restored.
  logic signed [27:0] x2a;
  logic signed [28:0] s3_b5_r;
  logic [UP_W-1:0]    s3_up_r;
  logic               s3_dz_r;
  assign x2a = sa.neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b5_r <= 29'(x2a) + 29'(sa.x1);
      s3_up_r <= sa.up;
      s3_dz_r <= sa.dz;
    end
  end

  // Stage 4: temperature with saturation, and B6.
  logic signed [28:0] b5p8;
  logic signed [24:0] tf;
  logic               tsat4;
  tag_t               s4_tag_r;
  logic signed [28:0] s4_b6_r;
  logic [UP_W-1:0]    s4_up_r;
  assign b5p8  = s3_b5_r + 29'sd8;
  assign tf    = b5p8[28:4];
  assign tsat4 = (tf > 25'(TEMP_MAX)) || (tf < 25'(TEMP_MIN));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag_r.t    <= tsat4 ? (tf[24] ? 16'(TEMP_MIN) : 16'(TEMP_MAX)) : tf[15:0];
      s4_tag_r.tsat <= tsat4;
      s4_tag_r.dz   <= s3_dz_r;
      s4_b6_r       <= s3_b5_r - 29'(B6_OFFSET);
      s4_up_r       <= s3_up_r;
    end
  end

  // Stage 5: B6 squared and the two AC*B6 products.
  logic signed [57:0] s5_sq_r;
  logic signed [44:0] s5_ac2b6_r, s5_ac3b6_r;
  tag_t               s5_tag_r;
  logic [UP_W-1:0]    s5_up_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq_r    <= s4_b6_r * s4_b6_r;
      s5_ac2b6_r <= ac2 * s4_b6_r;
      s5_ac3b6_r <= ac3 * s4_b6_r;
      s5_tag_r   <= s4_tag_r;
      s5_up_r    <= s4_up_r;
    end
  end

  // Stage 6: B2 and B1 times the shifted square, as two partial products each.
  logic [45:0]        sq;
  logic signed [39:0] s6_b2l_r, s6_b2h_r, s6_b1l_r, s6_b1h_r;
  logic signed [44:0] s6_ac2b6_r, s6_ac3b6_r;
  tag_t               s6_tag_r;
  logic [UP_W-1:0]    s6_up_r;
  assign sq = s5_sq_r[57:12];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_b2l_r   <= b2 * $signed({1'b0, sq[22:0]});
      s6_b2h_r   <= b2 * $signed({1'b0, sq[45:23]});
      s6_b1l_r   <= b1 * $signed({1'b0, sq[22:0]});
      s6_b1h_r   <= b1 * $signed({1'b0, sq[45:23]});
      s6_ac2b6_r <= s5_ac2b6_r;
      s6_ac3b6_r <= s5_ac3b6_r;
      s6_tag_r   <= s5_tag_r;
      s6_up_r    <= s5_up_r;
    end
  end

  // Stage 7: join the partial products.
  logic signed [63:0] s7_b2sq_r, s7_b1sq_r;
  logic signed [44:0] s7_ac2b6_r, s7_ac3b6_r;
  tag_t               s7_tag_r;
  logic [UP_W-1:0]    s7_up_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b2sq_r  <= (64'(s6_b2h_r) <<< 23) + 64'(s6_b2l_r);
      s7_b1sq_r  <= (64'(s6_b1h_r) <<< 23) + 64'(s6_b1l_r);
      s7_ac2b6_r <= s6_ac2b6_r;
      s7_ac3b6_r <= s6_ac3b6_r;
      s7_tag_r   <= s6_tag_r;
      s7_up_r    <= s6_up_r;
    end
  end

  // Stage 8: X3 sums for B3 and for B4.
  logic signed [63:0] s8_x3_r, s8_xb_r;
  tag_t               s8_tag_r;
  logic [UP_W-1:0]    s8_up_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_x3_r  <= (s7_b2sq_r >>> 11) + (64'(s7_ac2b6_r) >>> 11);
      s8_xb_r  <= (64'(s7_ac3b6_r) >>> 13) + (s7_b1sq_r >>> 16);
      s8_tag_r <= s7_tag_r;
      s8_up_r  <= s7_up_r;
    end
  end

  // Stage 9: B3 (low word only is needed) and the B4 multiplicand.
  logic signed [63:0] b3a, b3s, b3r, ubr;
  logic [31:0]        s9_b3_r, s9_u_r;
  tag_t               s9_tag_r;
  logic [UP_W-1:0]    s9_up_r;
  assign b3a = (64'(ac1) <<< 2) + s8_x3_r;
  assign b3s = b3a <<< oss_r;
  assign b3r = b3s + 64'sd2;
  assign ubr = s8_xb_r + 64'sd2;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_b3_r  <= b3r[33:2];
      s9_u_r   <= ubr[33:2] + 32'(B4_OFFSET);
      s9_tag_r <= s8_tag_r;
      s9_up_r  <= s8_up_r;
    end
  end

  // Stage 10: B4 and B7, both modulo 2^32.
  logic [47:0] b4p, b7p;
  logic [15:0] pscale;
  logic [31:0] updiff;
  logic [16:0] s10_b4_r;
  logic [31:0] s10_b7_r;
  tag_t        s10_tag_r;
  assign b4p    = ac4 * s9_u_r;
  assign pscale = 16'(P_SCALE >> oss_r);
  assign updiff = 32'(s9_up_r) - s9_b3_r;
  assign b7p    = updiff * pscale;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_b4_r  <= b4p[31:15];
      s10_b7_r  <= b7p[31:0];
      s10_tag_r <= s9_tag_r;
    end
  end

  // Pressure divide: B7*2/B4 while B7 is below 2^31, else (B7/B4)*2.
  side_b_t               sb_in, sb;
  logic [DIVB_NUM_W-1:0] numb, qb;
  assign sb_in.tag.t    = s10_tag_r.t;
  assign sb_in.tag.tsat = s10_tag_r.tsat;
  assign sb_in.tag.dz   = s10_tag_r.dz || (s10_b4_r == '0);
  assign sb_in.big      = s10_b7_r[31];
  assign numb = s10_b7_r[31] ? s10_b7_r : {s10_b7_r[30:0], 1'b0};

  btpc_div #(.NUM_W(DIVB_NUM_W), .DEN_W(DIVB_DEN_W), .SIDE_W($bits(side_b_t))) u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s10_vld_r),
    .num(numb), .den(s10_b4_r), .side(sb_in),
    .out_vld(db_vld), .quo(qb), .out_side(sb)
  );

  // Stage 12: P, with a flag when it is already past the pressure range.
  logic [32:0] pw;
  logic [19:0] s12_p_r;
  logic        s12_pbig_r;
  tag_t        s12_tag_r;
  assign pw = sb.big ? {qb, 1'b0} : {1'b0, qb};

  always_ff @(posedge clk) begin
    if (en) begin
      s12_p_r    <= pw[19:0];
      s12_pbig_r <= |pw[32:20];
      s12_tag_r  <= sb.tag;
    end
  end

  // Stage 13: (P>>8)^2 and the linear term.
  localparam logic signed [14:0] LIN_K = -15'(P_LIN_K);
  logic [23:0]        s13_sqp_r;
  logic signed [35:0] s13_lin_r;
  logic [19:0]        s13_p_r;
  logic               s13_pbig_r;
  tag_t               s13_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s13_sqp_r  <= s12_p_r[19:8] * s12_p_r[19:8];
      s13_lin_r  <= LIN_K * $signed({1'b0, s12_p_r});
      s13_p_r    <= s12_p_r;
      s13_pbig_r <= s12_pbig_r;
      s13_tag_r  <= s12_tag_r;
    end
  end

  // Stage 14: scale the square term; shift the linear term.
  logic [35:0]        sqk;
  logic [19:0]        s14_x1_r;
  logic signed [19:0] s14_x2_r;
  logic [19:0]        s14_p_r;
  logic               s14_pbig_r;
  tag_t               s14_tag_r;
  assign sqk = s13_sqp_r * 12'(P_SQ_K);

  always_ff @(posedge clk) begin
    if (en) begin
      s14_x1_r   <= sqk[35:16];
      s14_x2_r   <= s13_lin_r[35:16];
      s14_p_r    <= s13_p_r;
      s14_pbig_r <= s13_pbig_r;
      s14_tag_r  <= s13_tag_r;
    end
  end

  // Final correction, saturation and status into the result register.
  logic signed [22:0] csum, pf;
  logic signed [18:0] corr;
  logic               psat;
  logic signed [TEMP_W-1:0] t_nxt, t_r;
  logic [PRES_W-1:0]        p_nxt, p_r;
  status_t                  st_nxt, st_r;
  assign csum = $signed({3'b0, s14_x1_r}) + 23'(s14_x2_r) + 23'(P_OFFSET);
  assign corr = csum[22:4];
  assign pf   = $signed({3'b0, s14_p_r}) + 23'(corr);

  always_comb begin
    psat  = s14_pbig_r || (pf > 23'(PRES_MAX)) || pf[22];
    t_nxt = s14_tag_r.t;
    if (s14_pbig_r || (!pf[22] && (pf > 23'(PRES_MAX)))) begin
      p_nxt = PRES_W'(PRES_MAX);
    end else if (pf[22]) begin
      p_nxt = '0;
    end else begin
      p_nxt = pf[19:0];
    end
    st_nxt = (psat || s14_tag_r.tsat) ? ST_SAT : ST_OK;
    if (s14_tag_r.dz) begin
      t_nxt  = '0;
      p_nxt  = '0;
      st_nxt = ST_DIV0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      p_r  <= p_nxt;
      st_r <= st_nxt;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
      s14_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_chan.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= da_vld;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= s9_vld_r;
      s12_vld_r <= db_vld;
      s13_vld_r <= s12_vld_r;
      s14_vld_r <= s13_vld_r;
      out_vld_r <= s14_vld_r;
    end
  end

  assign out_chan.valid              = out_vld_r;
  assign out_chan.temperature_tenths = t_r;
  assign out_chan.pressure_pa        = p_r;
  assign out_chan.status             = st_r;

  // A divide-by-zero result carries zero values.
  `BTPC_ASSERT_NOW(a_div0_zero, out_vld_r && (st_r == ST_DIV0), (t_r == '0) && (p_r == '0), "div0 result not zero")
  // While stalled, the checked valid bits (stage 5, stage 12, result) may not change.
  `BTPC_ASSERT_NEXT(a_stall_hold, !en, $stable(s5_vld_r) && $stable(s12_vld_r) && $stable(out_vld_r), "valid moved during stall")
  // A valid result always carries one of the three defined status codes.
  `BTPC_ASSERT_NOW(a_sat_flag, out_vld_r, (st_r == ST_OK) || (st_r == ST_DIV0) || (st_r == ST_SAT), "reserved status code")
  // A result that is not taken stays in place, its temperature and status unchanged.
  `BTPC_ASSERT_NEXT(a_advance, out_vld_r && !out_chan.ready, out_vld_r && $stable(t_r) && $stable(st_r), "result lost while stalled")

endmodule

@@ rtl/core/btpc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on nothing; side data travels alongside each item.
module btpc_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W-1:0]  q_a [0:NUM_W];
  logic [DEN_W-1:0]  r_a [0:NUM_W];
  logic [DEN_W-1:0]  d_a [0:NUM_W];
  logic [SIDE_W-1:0] s_a [0:NUM_W];
  logic              v_a [0:NUM_W];

  assign q_a[0] = num;
  assign r_a[0] = '0;
  assign d_a[0] = den;
  assign s_a[0] = side;
  assign v_a[0] = in_vld;

  // Each stage shifts in one numerator bit and subtracts the divisor if it fits.
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [NUM_W-1:0]  q_r;
    logic [DEN_W-1:0]  r_r;
    logic [DEN_W-1:0]  d_r;
    logic [SIDE_W-1:0] s_r;
    logic              v_r;

    assign trial = {r_a[s], q_a[s][NUM_W-1]};
    assign diff  = trial - {1'b0, d_a[s]};
    assign ge    = trial >= {1'b0, d_a[s]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r <= {q_a[s][NUM_W-2:0], ge};
        r_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        d_r <= d_a[s];
        s_r <= s_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[s];
      end
    end

    assign q_a[s+1] = q_r;
    assign r_a[s+1] = r_r;
    assign d_a[s+1] = d_r;
    assign s_a[s+1] = s_r;
    assign v_a[s+1] = v_r;
  end

  assign out_vld  = v_a[NUM_W];
  assign quo      = q_a[NUM_W];
  assign out_side = s_a[NUM_W];

endmodule
